@@ rtl/rcbm_pkg.sv @@
// Shared types and constants for the random-coefficient biquad morph core.
// No dependencies; used by the core and its port checker.
package rcbm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int COUNT_BITS  = 21;
    localparam int NCOEF       = 5;
    localparam int LEN_BITS    = 20;
    localparam int SF_BITS     = 17;
    localparam int BAR_BITS    = 24;
    localparam int IN_BYTES    = 7;
    localparam int OUT_BYTES   = 14;
    localparam int ADDR_BITS   = 4;

    localparam logic [LEN_BITS-1:0]   CYCLE_LENGTH_RESET    = 20'd22050;
    localparam logic [SF_BITS-1:0]    SMOOTH_FRACTION_RESET = 17'd21845;
    localparam logic [SF_BITS-1:0]    SMOOTH_FULL           = 17'd65536;
    localparam logic [COEF_BITS-1:0]  COEF_HALF             = 16'd32768;

    typedef enum logic [1:0] {
        REG_CYCLE_LENGTH    = 2'd0,
        REG_SMOOTH_FRACTION = 2'd1,
        REG_HOST_SYNC       = 2'd2,
        REG_RANDOM_SEED     = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SYNC,
        S_MOD,
        S_FMUL,
        S_FSET,
        S_RAND,
        S_FCHK,
        S_FM1,
        S_FM2,
        S_FM3,
        S_FDIV,
        S_FEND,
        S_FILT,
        S_FOUT,
        S_DONE
    } state_t;

endpackage

@@ rtl/random_coefficient_biquad_morph_core.sv @@
// Stereo direct-form-I biquad with randomly retargeted, crossfaded coefficients.
// Depends on rcbm_pkg; one shared multiplier and one shift-subtract divider.
//
// One stream item is one stereo frame and gives one result item. The core takes
// one frame at a time: a frame without a crossfade step runs a sync step, two
// channels of five multiply-accumulates through the shared multiplier and an
// output load. A frame inside a crossfade adds, for each of the five
// coefficients, two products and a 16-step divide in the shared divider. A
// frame that retargets adds the fade length product and five generator steps,
// and a 24-step divide for the bar remainder when a resync is pending. s_tready
// is high only while the core waits for a frame; a finished result waits in the
// output register while the next frame is taken.
module random_coefficient_biquad_morph_core
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // left_sample, right_sample, samples_to_next_bar
    input  logic [rcbm_pkg::IN_BYTES*8-1:0]        s_tdata,
    // playback_restart
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // left_out, right_out, coef_a0, coef_a1, coef_a2, coef_b1, coef_b2
    output logic [rcbm_pkg::OUT_BYTES*8-1:0]       m_tdata,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [rcbm_pkg::ADDR_BITS-1:0]         paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import rcbm_pkg::*;

    logic [LEN_BITS-1:0]  cyc_len_reg;
    logic [SF_BITS-1:0]   smooth_reg;
    logic                 host_sync_reg;
    logic [31:0]          seed_reg;

    logic signed [SAMPLE_BITS-1:0] xh_reg [2][2];
    logic signed [SAMPLE_BITS-1:0] yh_reg [2][2];
    logic signed [SAMPLE_BITS-1:0] xh_next [2][2];
    logic signed [SAMPLE_BITS-1:0] yh_next [2][2];
    logic signed [COUNT_BITS-1:0]  cnt_reg, cnt_next;
    logic signed [COUNT_BITS-1:0]  rem_reg, rem_next;
    logic [LEN_BITS-1:0]           dur_reg, dur_next;
    logic [COEF_BITS-1:0]          start_reg [NCOEF];
    logic [COEF_BITS-1:0]          start_next [NCOEF];
    logic [COEF_BITS-1:0]          target_reg [NCOEF];
    logic [COEF_BITS-1:0]          target_next [NCOEF];
    logic [COEF_BITS-1:0]          active_reg [NCOEF];
    logic [COEF_BITS-1:0]          active_next [NCOEF];
    logic [31:0]                   rnd_reg, rnd_next;
    logic                          pend_reg, pend_next;

    logic signed [SAMPLE_BITS-1:0] in_smp_reg [2];
    logic [BAR_BITS-1:0]           bar_reg;
    logic                          restart_reg;
    logic signed [SAMPLE_BITS-1:0] yout_reg [2];
    logic signed [SAMPLE_BITS-1:0] yout_next [2];

    state_t                        state_reg, state_next;
    logic [2:0]                    idx_reg, idx_next;
    logic                          ch_reg, ch_next;
    logic [4:0]                    div_cnt_reg, div_cnt_next;
    logic [LEN_BITS-1:0]           div_rem_reg, div_rem_next;
    logic [BAR_BITS-1:0]           div_q_reg, div_q_next;
    logic [LEN_BITS-1:0]           div_d_reg, div_d_next;
    logic [36:0]                   num_reg, num_next;
    logic signed [39:0]            acc_reg, acc_next;
    logic signed [21:0]            mul_a;
    logic signed [17:0]            mul_b;
    logic signed [39:0]            prod_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [OUT_BYTES*8-1:0]        m_data_reg, m_data_next;

    logic                          cfg_wr;
    logic                          in_acc;
    logic                          out_load;
    logic                          pend_eff;
    logic signed [COUNT_BITS-1:0]  cnt_dec;
    logic [LEN_BITS-1:0]           len_eff;
    logic [SF_BITS-1:0]            sf_eff;
    logic [LEN_BITS:0]             div_shift;
    logic                          div_ge;
    logic [LEN_BITS-1:0]           div_rem_step;
    logic [BAR_BITS-1:0]           div_q_step;
    logic [31:0]                   x1, x2, x3;
    logic [36:0]                   num_sum;
    logic [LEN_BITS-1:0]           fade_len;
    logic signed [39:0]            acc_rnd;
    logic signed [23:0]            y_wide;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic [2:0]                    term;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_CYCLE_LENGTH:    prdata = {12'd0, cyc_len_reg};
            REG_SMOOTH_FRACTION: prdata = {15'd0, smooth_reg};
            REG_HOST_SYNC:       prdata = {31'd0, host_sync_reg};
            REG_RANDOM_SEED:     prdata = seed_reg;
            default:             prdata = '0;
        endcase
    end

    assign pend_eff = host_sync_reg && (pend_reg || restart_reg);
    assign cnt_dec  = ((host_sync_reg && restart_reg) ? '0 : cnt_reg) - COUNT_BITS'(1);
    assign len_eff  = (cyc_len_reg == '0) ? LEN_BITS'(1) : cyc_len_reg;
    assign sf_eff   = (smooth_reg > SMOOTH_FULL) ? SMOOTH_FULL : smooth_reg;

    assign div_shift    = {div_rem_reg, div_q_reg[BAR_BITS-1]};
    assign div_ge       = div_shift >= {1'b0, div_d_reg};
    assign div_rem_step = div_ge ? LEN_BITS'(div_shift - {1'b0, div_d_reg})
                                 : div_shift[LEN_BITS-1:0];
    assign div_q_step   = {div_q_reg[BAR_BITS-2:0], div_ge};

    assign x1 = rnd_reg ^ (rnd_reg << 13);
    assign x2 = x1 ^ (x1 >> 17);
    assign x3 = x2 ^ (x2 << 5);

    assign num_sum  = num_reg + prod_reg[36:0];
    assign fade_len = prod_reg[35:16];

    assign acc_rnd = acc_reg + 40'sd32768;
    assign y_wide  = 24'(acc_rnd >>> 16);
    assign y_sat   = (y_wide > 24'sd32767) ? 16'sh7fff :
                     (y_wide < -24'sd32768) ? 16'sh8000 : y_wide[15:0];
    assign term    = idx_reg - 3'd1;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_FMUL:
            begin
                mul_a = 22'(cnt_reg);
                mul_b = {1'b0, sf_eff};
            end
            S_FM1:
            begin
                mul_a = {2'b00, dur_reg - rem_reg[LEN_BITS-1:0]};
                mul_b = {2'b00, target_reg[idx_reg]};
            end
            S_FM2:
            begin
                mul_a = {2'b00, rem_reg[LEN_BITS-1:0]};
                mul_b = {2'b00, start_reg[idx_reg]};
            end
            S_FILT:
            begin
                case (idx_reg)
                    3'd0:    mul_a = 22'(in_smp_reg[ch_reg]);
                    3'd1:    mul_a = 22'(xh_reg[ch_reg][0]);
                    3'd2:    mul_a = 22'(xh_reg[ch_reg][1]);
                    3'd3:    mul_a = 22'(yh_reg[ch_reg][0]);
                    3'd4:    mul_a = 22'(yh_reg[ch_reg][1]);
                    default: mul_a = '0;
                endcase
                mul_b = (idx_reg < 3'd5) ? {2'b00, active_reg[idx_reg]} : '0;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_acc) state_next = S_SYNC;
            S_SYNC:
            begin
                if (cnt_dec[COUNT_BITS-1] || cnt_dec == '0)
                    state_next = pend_eff ? S_MOD : S_FMUL;
                else
                    state_next = S_FCHK;
            end
            S_MOD:   if (div_cnt_reg == 5'd1) state_next = S_FMUL;
            S_FMUL:  state_next = S_FSET;
            S_FSET:  state_next = S_RAND;
            S_RAND:  if (idx_reg == 3'd4) state_next = S_FCHK;
            S_FCHK:  state_next = rem_reg[COUNT_BITS-1] ? S_FILT : S_FM1;
            S_FM1:   state_next = S_FM2;
            S_FM2:   state_next = S_FM3;
            S_FM3:   state_next = S_FDIV;
            S_FDIV:
            begin
                if (div_cnt_reg == 5'd1)
                    state_next = (idx_reg == 3'd4) ? S_FEND : S_FM1;
            end
            S_FEND:  state_next = S_FILT;
            S_FILT:  if (idx_reg == 3'd5) state_next = S_FOUT;
            S_FOUT:  state_next = ch_reg ? S_DONE : S_FILT;
            S_DONE:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        xh_next      = xh_reg;
        yh_next      = yh_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        dur_next     = dur_reg;
        start_next   = start_reg;
        target_next  = target_reg;
        active_next  = active_reg;
        rnd_next     = rnd_reg;
        pend_next    = pend_reg;
        yout_next    = yout_reg;
        idx_next     = idx_reg;
        ch_next      = ch_reg;
        div_cnt_next = div_cnt_reg;
        div_rem_next = div_rem_reg;
        div_q_next   = div_q_reg;
        div_d_next   = div_d_reg;
        num_next     = num_reg;
        acc_next     = acc_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            S_SYNC:
            begin
                if (cnt_dec[COUNT_BITS-1] || cnt_dec == '0)
                begin
                    start_next = active_reg;
                    pend_next  = 1'b0;
                    cnt_next   = COUNT_BITS'(len_eff);
                    if (pend_eff)
                    begin
                        div_rem_next = '0;
                        div_q_next   = bar_reg;
                        div_d_next   = len_eff;
                        div_cnt_next = 5'd24;
                    end
                end
                else
                begin
                    cnt_next  = cnt_dec;
                    pend_next = pend_eff;
                end
            end
            S_MOD:
            begin
                div_rem_next = div_rem_step;
                div_q_next   = div_q_step;
                div_cnt_next = div_cnt_reg - 5'd1;
                if (div_cnt_reg == 5'd1)
                    cnt_next = COUNT_BITS'(div_rem_step);
            end
            S_FSET:
            begin
                rem_next = COUNT_BITS'(fade_len);
                dur_next = (fade_len == '0) ? LEN_BITS'(1) : fade_len;
                idx_next = '0;
            end
            S_RAND:
            begin
                rnd_next             = x3;
                target_next[idx_reg] = x3[31:16];
                idx_next             = idx_reg + 3'd1;
            end
            S_FCHK:
            begin
                idx_next = '0;
                ch_next  = 1'b0;
            end
            S_FM2:   num_next = prod_reg[36:0];
            S_FM3:
            begin
                div_rem_next = num_sum[35:16];
                div_q_next   = {num_sum[15:0], 8'd0};
                div_d_next   = dur_reg;
                div_cnt_next = 5'd16;
            end
            S_FDIV:
            begin
                div_rem_next = div_rem_step;
                div_q_next   = div_q_step;
                div_cnt_next = div_cnt_reg - 5'd1;
                if (div_cnt_reg == 5'd1)
                begin
                    active_next[idx_reg] = div_q_step[COEF_BITS-1:0];
                    idx_next             = idx_reg + 3'd1;
                end
            end
            S_FEND:
            begin
                rem_next = rem_reg - COUNT_BITS'(1);
                idx_next = '0;
                ch_next  = 1'b0;
            end
            S_FILT:
            begin
                if (idx_reg != 3'd0)
                begin
                    if (term >= 3'd3)
                        acc_next = ((idx_reg == 3'd1) ? 40'sd0 : acc_reg) - prod_reg;
                    else
                        acc_next = ((idx_reg == 3'd1) ? 40'sd0 : acc_reg) + prod_reg;
                end
                idx_next = idx_reg + 3'd1;
            end
            S_FOUT:
            begin
                xh_next[ch_reg][1] = xh_reg[ch_reg][0];
                xh_next[ch_reg][0] = in_smp_reg[ch_reg];
                yh_next[ch_reg][1] = yh_reg[ch_reg][0];
                yh_next[ch_reg][0] = y_sat;
                yout_next[ch_reg]  = y_sat;
                ch_next            = 1'b1;
                idx_next           = '0;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {active_reg[4], active_reg[3], active_reg[2],
                                    active_reg[1], active_reg[0],
                                    yout_reg[1], yout_reg[0]};
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
        if (cfg_wr)
        begin
            if (reg_idx_t'(paddr[3:2]) == REG_CYCLE_LENGTH)
                pend_next = 1'b1;
            if (reg_idx_t'(paddr[3:2]) == REG_RANDOM_SEED)
                rnd_next = (pwdata == '0) ? 32'd1 : pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyc_len_reg   <= CYCLE_LENGTH_RESET;
            smooth_reg    <= SMOOTH_FRACTION_RESET;
            host_sync_reg <= 1'b1;
            seed_reg      <= 32'd1;
            for (int c = 0; c < 2; c++)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    xh_reg[c][k] <= '0;
                    yh_reg[c][k] <= '0;
                end
            end
            for (int i = 0; i < NCOEF; i++)
            begin
                start_reg[i]  <= '0;
                target_reg[i] <= '0;
                active_reg[i] <= COEF_HALF;
            end
            cnt_reg     <= COUNT_BITS'(1);
            rem_reg     <= COUNT_BITS'(1);
            dur_reg     <= LEN_BITS'(1);
            rnd_reg     <= 32'd1;
            pend_reg    <= 1'b1;
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            ch_reg      <= 1'b0;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (reg_idx_t'(paddr[3:2]))
                    REG_CYCLE_LENGTH:    cyc_len_reg   <= pwdata[LEN_BITS-1:0];
                    REG_SMOOTH_FRACTION: smooth_reg    <= pwdata[SF_BITS-1:0];
                    REG_HOST_SYNC:       host_sync_reg <= pwdata[0];
                    REG_RANDOM_SEED:     seed_reg      <= pwdata;
                    default:             seed_reg      <= seed_reg;
                endcase
            end
            xh_reg      <= xh_next;
            yh_reg      <= yh_next;
            start_reg   <= start_next;
            target_reg  <= target_next;
            active_reg  <= active_next;
            cnt_reg     <= cnt_next;
            rem_reg     <= rem_next;
            dur_reg     <= dur_next;
            rnd_reg     <= rnd_next;
            pend_reg    <= pend_next;
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            ch_reg      <= ch_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_smp_reg[0] <= s_tdata[15:0];
            in_smp_reg[1] <= s_tdata[31:16];
            bar_reg       <= s_tdata[55:32];
            restart_reg   <= s_tuser;
        end
        yout_reg    <= yout_next;
        div_rem_reg <= div_rem_next;
        div_q_reg   <= div_q_next;
        div_d_reg   <= div_d_next;
        num_reg     <= num_next;
        acc_reg     <= acc_next;
        prod_reg    <= mul_a * mul_b;
        m_data_reg  <= m_data_next;
    end

endmodule

@@ rtl/rcbm_checker.sv @@
// Port-level checks for random_coefficient_biquad_morph_core, bound to the top.
// Depends on rcbm_pkg for port widths.
module rcbm_assertions
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [rcbm_pkg::IN_BYTES*8-1:0]     s_tdata,
    input logic                                s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [rcbm_pkg::OUT_BYTES*8-1:0]    m_tdata,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [rcbm_pkg::ADDR_BITS-1:0]      paddr,
    input logic [31:0]                         pwdata,
    input logic [31:0]                         prdata,
    input logic                                pready
);
    import rcbm_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result item changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while previous item in work");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result item appeared right after accept");

    a_host_rd: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr[3:2] == REG_HOST_SYNC
        |=> (paddr[3:2] != REG_HOST_SYNC) || (prdata[31:1] == '0))
        else $error("host sync read back wider than one bit");

endmodule

bind random_coefficient_biquad_morph_core rcbm_assertions u_rcbm_assertions (.*);
